FILE: src/mmm_pkg.sv
`default_nettype none

package mmm_pkg;

    localparam int CMD_W     = 13;
    localparam int TERM_W    = 16;
    localparam int IDX_W     = 3;
    localparam int FRAC_W    = 16;
    localparam int YAW_W     = 18;
    localparam int ROLLW_W   = 33;
    localparam int INT_W     = 20;
    localparam int MIX_W     = 36;
    localparam int EXC_W     = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam int QUAD_MOTORS = 4;
    localparam int HEX_MOTORS  = 6;

    // 0.866025 in q0.16
    localparam logic [FRAC_W:0] HEX_ROLL = 17'd56756;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIXER_TYPE    = 3'd0,
        CFG_YAW_DIRECTION = 3'd1,
        CFG_MIN_THROTTLE  = 3'd2,
        CFG_MAX_THROTTLE  = 3'd3,
        CFG_MIN_CHECK     = 3'd4,
        CFG_MIN_COMMAND   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        COEF_ZERO,
        COEF_POS,
        COEF_NEG
    } coef_t;

    typedef struct packed {
        logic              mixer_type;
        logic signed [1:0] yaw_direction;
        logic [CMD_W-1:0]  min_throttle;
        logic [CMD_W-1:0]  max_throttle;
        logic [CMD_W-1:0]  min_check;
        logic [CMD_W-1:0]  min_command;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] count;
        logic [EXC_W-1:0] excess;
        logic             force_min;
        logic             disarmed;
    } mix_ctl_t;

    typedef logic signed [MIX_W-1:0] mix_t;

    function automatic logic roll_neg(input logic hex, input logic [IDX_W-1:0] idx);
        logic neg;
        if (hex)
        begin
            neg = (idx == 3'd1) || (idx == 3'd2) || (idx == 3'd3);
        end
        else
        begin
            neg = (idx == 3'd1) || (idx == 3'd2);
        end
        return neg;
    endfunction

    function automatic coef_t pitch_coef(input logic hex, input logic [IDX_W-1:0] idx);
        coef_t c;
        if (hex)
        begin
            unique case (idx)
                3'd0, 3'd1: c = COEF_NEG;
                3'd3, 3'd4: c = COEF_POS;
                default:    c = COEF_ZERO;
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0, 3'd1: c = COEF_NEG;
                3'd2, 3'd3: c = COEF_POS;
                default:    c = COEF_ZERO;
            endcase
        end
        return c;
    endfunction

    // same yaw pattern on both layouts
    function automatic logic yaw_neg(input logic [IDX_W-1:0] idx);
        return !idx[0];
    endfunction

endpackage

`default_nettype wire

FILE: src/mmm_sample_if.sv
`default_nettype none

interface mmm_sample_if;
    logic                            valid;
    logic                            ready;
    logic [mmm_pkg::CMD_W-1:0]       throttle_level;
    logic signed [mmm_pkg::TERM_W-1:0] roll_term;
    logic signed [mmm_pkg::TERM_W-1:0] pitch_term;
    logic signed [mmm_pkg::TERM_W-1:0] yaw_term;
    logic [mmm_pkg::CMD_W-1:0]       stick_throttle;
    logic                            throttle_only_mode;
    logic                            is_armed;

    modport source (
        output valid, throttle_level, roll_term, pitch_term, yaw_term,
               stick_throttle, throttle_only_mode, is_armed,
        input  ready
    );
    modport sink (
        input  valid, throttle_level, roll_term, pitch_term, yaw_term,
               stick_throttle, throttle_only_mode, is_armed,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/mmm_motor_if.sv
`default_nettype none

interface mmm_motor_if;
    logic                      valid;
    logic                      ready;
    logic [mmm_pkg::IDX_W-1:0] motor_index;
    logic [mmm_pkg::CMD_W-1:0] motor_value;
    logic                      last_of_run;

    modport source (
        output valid, motor_index, motor_value, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, motor_index, motor_value, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/mmm_cfg_if.sv
`default_nettype none

interface mmm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mmm_pkg::CFG_IDX_W-1:0] index;
    logic [mmm_pkg::CFG_DAT_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/multirotor_motor_mixer_core.sv
`default_nettype none

// a sample transfer passes the front stages, the two-entry queue and the output register
// to its first motor command, then one motor command per cycle while motor.ready stays
// high (4 for quad x, 6 for hex x); that single output register sets how often samples
// are taken, and the front pipeline runs ahead
// reset: config registers return to defaults, pipeline and two-entry queue are emptied
module multirotor_motor_mixer_core #(
    parameter int MAX_MOTORS = 6
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mmm_sample_if.sink  sample,
    mmm_cfg_if.sink     cfg,
    mmm_motor_if.source motor
);
    import mmm_pkg::*;

    localparam int ENTRY_W = $bits(mix_ctl_t) + MAX_MOTORS * MIX_W;

    cfg_t                  cfg_cur;
    logic                  f_valid;
    mix_ctl_t              f_ctl;
    mix_t [MAX_MOTORS-1:0] f_mix;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [ENTRY_W-1:0]    q_data;
    mix_ctl_t              q_ctl;
    mix_t [MAX_MOTORS-1:0] q_mix;

    assign {q_ctl, q_mix} = q_data;

    mmm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    mmm_front #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .cfg       (cfg_cur),
        .q_full    (q_full),
        .out_valid (f_valid),
        .out_ctl   (f_ctl),
        .out_mix   (f_mix)
    );

    mmm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_data  ({f_ctl, f_mix}),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    mmm_back #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_cur),
        .q_valid (q_valid),
        .q_ctl   (q_ctl),
        .q_mix   (q_mix),
        .q_pop   (q_pop),
        .motor   (motor)
    );

endmodule

`default_nettype wire

FILE: src/mmm_cfg_regs.sv
`default_nettype none

module mmm_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mmm_cfg_if.sink      cfg,
    output mmm_pkg::cfg_t cfg_out
);
    import mmm_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mixer_type    <= 1'b0;
            cfg_reg.yaw_direction <= 2'sd1;
            cfg_reg.min_throttle  <= 13'd2000;
            cfg_reg.max_throttle  <= 13'd4000;
            cfg_reg.min_check     <= 13'd2100;
            cfg_reg.min_command   <= 13'd2000;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_MIXER_TYPE:    cfg_reg.mixer_type    <= cfg.data[0];
                CFG_YAW_DIRECTION: cfg_reg.yaw_direction <= $signed(cfg.data[1:0]);
                CFG_MIN_THROTTLE:  cfg_reg.min_throttle  <= cfg.data;
                CFG_MAX_THROTTLE:  cfg_reg.max_throttle  <= cfg.data;
                CFG_MIN_CHECK:     cfg_reg.min_check     <= cfg.data;
                CFG_MIN_COMMAND:   cfg_reg.min_command   <= cfg.data;
                default:           ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/mmm_front.sv
`default_nettype none

module mmm_front #(
    parameter int MAX_MOTORS = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    mmm_sample_if.sink                         sample,
    input  wire mmm_pkg::cfg_t                 cfg,
    input  wire logic                          q_full,
    output logic                               out_valid,
    output mmm_pkg::mix_ctl_t                  out_ctl,
    output mmm_pkg::mix_t [MAX_MOTORS-1:0]     out_mix
);
    import mmm_pkg::*;

    localparam int NPAIR = (MAX_MOTORS + 1) / 2;
    localparam logic [IDX_W-1:0] QUAD_N = IDX_W'(QUAD_MOTORS);
    localparam logic [IDX_W-1:0] HEX_N  =
        IDX_W'((MAX_MOTORS < HEX_MOTORS) ? MAX_MOTORS : HEX_MOTORS);

    logic en;

    // stage 1: products and flags
    logic                       s1_valid_reg;
    logic [CMD_W-1:0]           s1_thr_reg;
    logic signed [TERM_W-1:0]   s1_pitch_reg;
    logic signed [YAW_W-1:0]    s1_yaw_reg;
    logic signed [ROLLW_W-1:0]  s1_roll_reg;
    logic                       s1_hex_reg;
    logic [IDX_W-1:0]           s1_count_reg;
    logic                       s1_force_reg;
    logic                       s1_disarm_reg;

    logic signed [YAW_W-1:0]    yaw_ext;
    logic signed [YAW_W-1:0]    ydir_ext;
    logic signed [YAW_W-1:0]    yaw_next;
    logic signed [ROLLW_W-1:0]  roll_ext;
    logic signed [ROLLW_W-1:0]  roll_hex;
    logic signed [ROLLW_W-1:0]  roll_next;

    // stage 2: motor mixes
    logic                       s2_valid_reg;
    mix_t [MAX_MOTORS-1:0]      s2_mix_reg;
    mix_t [MAX_MOTORS-1:0]      mix_next;
    logic [IDX_W-1:0]           s2_count_reg;
    logic                       s2_force_reg;
    logic                       s2_disarm_reg;

    // stage 3: pairwise maxima
    logic                       s3_valid_reg;
    mix_t [MAX_MOTORS-1:0]      s3_mix_reg;
    mix_t [NPAIR-1:0]           s3_pmax_reg;
    mix_t [NPAIR-1:0]           pmax_next;
    logic [NPAIR-1:0]           s3_pvld_reg;
    logic [NPAIR-1:0]           pvld_next;
    logic [IDX_W-1:0]           s3_count_reg;
    logic                       s3_force_reg;
    logic                       s3_disarm_reg;

    // stage 4: largest motor
    logic                       s4_valid_reg;
    mix_t [MAX_MOTORS-1:0]      s4_mix_reg;
    mix_t                       s4_big_reg;
    mix_t                       big_next;
    logic [IDX_W-1:0]           s4_count_reg;
    logic                       s4_force_reg;
    logic                       s4_disarm_reg;

    // stage 5: excess over max throttle
    logic                       s5_valid_reg;
    mix_t [MAX_MOTORS-1:0]      s5_mix_reg;
    mix_ctl_t                   s5_ctl_reg;
    logic signed [INT_W-1:0]    big_int;
    logic signed [INT_W-1:0]    max_ext;
    logic signed [INT_W-1:0]    exc_diff;
    logic [EXC_W-1:0]           excess_next;

    assign en           = !s5_valid_reg || !q_full;
    assign sample.ready = en;

    assign out_valid = s5_valid_reg;
    assign out_ctl   = s5_ctl_reg;
    assign out_mix   = s5_mix_reg;

    always_comb
    begin
        yaw_ext   = YAW_W'(sample.yaw_term);
        ydir_ext  = YAW_W'($signed(cfg.yaw_direction));
        yaw_next  = yaw_ext * ydir_ext;
        roll_ext  = ROLLW_W'(sample.roll_term);
        roll_hex  = roll_ext * $signed({{(ROLLW_W-FRAC_W-1){1'b0}}, HEX_ROLL});
        roll_next = cfg.mixer_type ? roll_hex : (roll_ext <<< FRAC_W);
    end

    always_comb
    begin
        logic signed [INT_W-1:0] ip;
        logic signed [INT_W-1:0] pitch_e;
        logic signed [INT_W-1:0] yaw_e;
        logic signed [MIX_W-1:0] roll_e;
        logic signed [MIX_W-1:0] int_sh;
        pitch_e = INT_W'(s1_pitch_reg);
        yaw_e   = INT_W'(s1_yaw_reg);
        roll_e  = MIX_W'(s1_roll_reg);
        for (int i = 0; i < MAX_MOTORS; i++)
        begin
            ip = $signed({{(INT_W-CMD_W){1'b0}}, s1_thr_reg});
            unique case (pitch_coef(s1_hex_reg, IDX_W'(i)))
                COEF_POS: ip = ip + pitch_e;
                COEF_NEG: ip = ip - pitch_e;
                default:  ;
            endcase
            ip = yaw_neg(IDX_W'(i)) ? (ip - yaw_e) : (ip + yaw_e);
            int_sh = {ip, {FRAC_W{1'b0}}};
            mix_next[i] = roll_neg(s1_hex_reg, IDX_W'(i)) ? (int_sh - roll_e)
                                                           : (int_sh + roll_e);
        end
    end

    for (genvar k = 0; k < NPAIR; k++)
    begin : g_pair
        if (2 * k + 1 < MAX_MOTORS)
        begin : g_two
            logic hi_ok;
            assign hi_ok = IDX_W'(2 * k + 1) < s2_count_reg;
            assign pmax_next[k] = (hi_ok && (s2_mix_reg[2*k+1] > s2_mix_reg[2*k]))
                                  ? s2_mix_reg[2*k+1] : s2_mix_reg[2*k];
        end
        else
        begin : g_one
            assign pmax_next[k] = s2_mix_reg[2*k];
        end
        assign pvld_next[k] = IDX_W'(2 * k) < s2_count_reg;
    end

    always_comb
    begin
        big_next = s3_pmax_reg[0];
        for (int k = 1; k < NPAIR; k++)
        begin
            if (s3_pvld_reg[k] && (s3_pmax_reg[k] > big_next))
            begin
                big_next = s3_pmax_reg[k];
            end
        end
    end

    // floor equals truncation wherever the excess test can pass
    always_comb
    begin
        big_int     = s4_big_reg[MIX_W-1:FRAC_W];
        max_ext     = $signed({{(INT_W-CMD_W){1'b0}}, cfg.max_throttle});
        exc_diff    = big_int - max_ext;
        excess_next = (big_int > max_ext) ? exc_diff[EXC_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= sample.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_thr_reg    <= sample.throttle_level;
            s1_pitch_reg  <= sample.pitch_term;
            s1_yaw_reg    <= yaw_next;
            s1_roll_reg   <= roll_next;
            s1_hex_reg    <= cfg.mixer_type;
            s1_count_reg  <= cfg.mixer_type ? HEX_N : QUAD_N;
            s1_force_reg  <= (sample.stick_throttle < cfg.min_check)
                             && sample.throttle_only_mode;
            s1_disarm_reg <= !sample.is_armed;

            s2_mix_reg    <= mix_next;
            s2_count_reg  <= s1_count_reg;
            s2_force_reg  <= s1_force_reg;
            s2_disarm_reg <= s1_disarm_reg;

            s3_mix_reg    <= s2_mix_reg;
            s3_pmax_reg   <= pmax_next;
            s3_pvld_reg   <= pvld_next;
            s3_count_reg  <= s2_count_reg;
            s3_force_reg  <= s2_force_reg;
            s3_disarm_reg <= s2_disarm_reg;

            s4_mix_reg    <= s3_mix_reg;
            s4_big_reg    <= big_next;
            s4_count_reg  <= s3_count_reg;
            s4_force_reg  <= s3_force_reg;
            s4_disarm_reg <= s3_disarm_reg;

            s5_mix_reg           <= s4_mix_reg;
            s5_ctl_reg.count     <= s4_count_reg;
            s5_ctl_reg.excess    <= excess_next;
            s5_ctl_reg.force_min <= s4_force_reg;
            s5_ctl_reg.disarmed  <= s4_disarm_reg;
        end
    end

endmodule

`default_nettype wire

FILE: src/mmm_queue.sv
`default_nettype none

module mmm_queue #(
    parameter int WIDTH = 240,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == DEPTH_CNT;
    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/mmm_back.sv
`default_nettype none

module mmm_back #(
    parameter int MAX_MOTORS = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mmm_pkg::cfg_t                 cfg,
    input  wire logic                          q_valid,
    input  wire mmm_pkg::mix_ctl_t             q_ctl,
    input  wire mmm_pkg::mix_t [MAX_MOTORS-1:0] q_mix,
    output logic                               q_pop,
    mmm_motor_if.source                        motor
);
    import mmm_pkg::*;

    localparam int SEL_W = $clog2(MAX_MOTORS);
    localparam int V_W   = MIX_W + 1;
    localparam logic [IDX_W-1:0] HEX_N =
        IDX_W'((MAX_MOTORS < HEX_MOTORS) ? MAX_MOTORS : HEX_MOTORS);

    logic             out_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] index_reg;
    logic [CMD_W-1:0] value_reg;
    logic             last_reg;

    logic                  advance;
    logic                  load;
    logic                  last;
    mix_t                  sel;
    logic signed [V_W-1:0] sel_ext;
    logic signed [V_W-1:0] exc_sh;
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] lo;
    logic signed [V_W-1:0] hi;
    logic [CMD_W-1:0]      value_next;

    assign advance = !out_valid_reg || motor.ready;
    assign load    = advance && q_valid;
    assign last    = idx_reg == (q_ctl.count - 1'b1);
    assign q_pop   = load && last;

    assign motor.valid       = out_valid_reg;
    assign motor.motor_index = index_reg;
    assign motor.motor_value = value_reg;
    assign motor.last_of_run = last_reg;

    always_comb
    begin
        sel     = q_mix[idx_reg[SEL_W-1:0]];
        sel_ext = V_W'(sel);
        exc_sh  = $signed({{(V_W-EXC_W-FRAC_W){1'b0}}, q_ctl.excess, {FRAC_W{1'b0}}});
        v       = sel_ext - exc_sh;
        lo      = $signed({{(V_W-CMD_W-FRAC_W){1'b0}}, cfg.min_throttle, {FRAC_W{1'b0}}});
        hi      = $signed({{(V_W-CMD_W-FRAC_W){1'b0}}, cfg.max_throttle, {FRAC_W{1'b0}}});
        priority if (v < lo)
        begin
            value_next = cfg.min_throttle;
        end
        else if (v > hi)
        begin
            value_next = cfg.max_throttle;
        end
        else
        begin
            value_next = v[FRAC_W +: CMD_W];
        end
        if (q_ctl.force_min)
        begin
            value_next = cfg.min_throttle;
        end
        if (q_ctl.disarmed)
        begin
            value_next = cfg.min_command;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= q_valid;
            end
            if (load)
            begin
                idx_reg <= last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= idx_reg;
            value_reg <= value_next;
            last_reg  <= last;
        end
    end

`ifndef ASSERT_OFF
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        motor.valid |-> (motor.motor_index < HEX_N))
        else $error("motor index beyond motor count");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (motor.valid && motor.ready && !motor.last_of_run) |=>
        (motor.valid && (motor.motor_index == $past(motor.motor_index) + 1'b1)))
        else $error("sample run broken or skipped a motor");

    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (motor.valid && motor.ready && motor.last_of_run) |=>
        (!motor.valid || (motor.motor_index == '0)))
        else $error("new sample does not start at motor zero");
`endif

endmodule

`default_nettype wire

FILE: verif/multirotor_motor_mixer_core_tb.sv
`default_nettype none

module multirotor_motor_mixer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmm_pkg::*;

    localparam int  DRAIN_CYCLES = 24;
    localparam int  HOLD_CYCLES  = 300;
    localparam longint ONE_Q16   = 65536;
    localparam longint HEX_W_Q16 = 56756;

    typedef struct packed {
        logic [CMD_W-1:0]         throttle;
        logic signed [TERM_W-1:0] roll;
        logic signed [TERM_W-1:0] pitch;
        logic signed [TERM_W-1:0] yaw;
        logic [CMD_W-1:0]         stick;
        logic                     tonly;
        logic                     armed;
    } ctl_sample_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CMD_W-1:0] value;
        logic             last;
    } motor_cmd_t;

    logic clk;
    logic rst_n;

    mmm_sample_if sample_ch ();
    mmm_cfg_if    cfg_ch ();
    mmm_motor_if  motor_ch ();

    multirotor_motor_mixer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .cfg    (cfg_ch),
        .motor  (motor_ch)
    );

    // local copy of the mixer registers
    logic              cfg_hex     = 1'b0;
    logic signed [1:0] cfg_yaw     = 2'sd1;
    logic [CMD_W-1:0]  cfg_min_thr = 13'd2000;
    logic [CMD_W-1:0]  cfg_max_thr = 13'd4000;
    logic [CMD_W-1:0]  cfg_min_chk = 13'd2100;
    logic [CMD_W-1:0]  cfg_min_cmd = 13'd2000;

    motor_cmd_t pending_cmds[$];
    int         error_count = 0;
    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         hold_stamp  = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // expected motor commands for one sample
    function automatic void predict_motors(input ctl_sample_t s);
        longint mix [HEX_MOTORS];
        longint thr, roll, pitch, yaw, rw, pw, yw;
        longint top, top_int, lo, hi, cmd, v;
        int n;
        motor_cmd_t c;
        thr   = longint'(s.throttle);
        roll  = longint'($signed(s.roll));
        pitch = longint'($signed(s.pitch));
        yaw   = longint'($signed(s.yaw));
        yw    = longint'(cfg_yaw);
        yaw   = yaw * yw;
        lo    = longint'(cfg_min_thr);
        hi    = longint'(cfg_max_thr);
        cmd   = longint'(cfg_min_cmd);
        n     = cfg_hex ? HEX_MOTORS : QUAD_MOTORS;
        for (int i = 0; i < n; i++)
        begin
            if (cfg_hex)
            begin
                rw = (i >= 1 && i <= 3) ? -HEX_W_Q16 : HEX_W_Q16;
                pw = (i <= 1) ? -1 : ((i == 2 || i == 5) ? 0 : 1);
            end
            else
            begin
                rw = (i == 1 || i == 2) ? -ONE_Q16 : ONE_Q16;
                pw = (i <= 1) ? -1 : 1;
            end
            yw = (i % 2 == 0) ? -1 : 1;
            mix[i] = thr * ONE_Q16 + roll * rw + pitch * pw * ONE_Q16 + yaw * yw * ONE_Q16;
        end
        top = mix[0];
        for (int i = 1; i < n; i++)
            if (mix[i] > top)
                top = mix[i];
        // signed division truncates toward zero
        top_int = top / ONE_Q16;
        for (int i = 0; i < n; i++)
        begin
            v = mix[i];
            if (top_int > hi)
                v = v - (top_int - hi) * ONE_Q16;
            if (v < lo * ONE_Q16)
                v = lo * ONE_Q16;
            else if (v > hi * ONE_Q16)
                v = hi * ONE_Q16;
            if (s.tonly && s.stick < cfg_min_chk)
                v = lo * ONE_Q16;
            if (!s.armed)
                v = cmd * ONE_Q16;
            c.idx   = i[IDX_W-1:0];
            c.value = v[28:16];
            c.last  = (i == n - 1);
            pending_cmds.push_back(c);
        end
    endfunction

    function automatic ctl_sample_t sample_of(
        input logic [CMD_W-1:0]         throttle,
        input logic signed [TERM_W-1:0] roll,
        input logic signed [TERM_W-1:0] pitch,
        input logic signed [TERM_W-1:0] yaw,
        input logic [CMD_W-1:0]         stick,
        input logic                     tonly,
        input logic                     armed
    );
        ctl_sample_t s;
        s.throttle = throttle;
        s.roll     = roll;
        s.pitch    = pitch;
        s.yaw      = yaw;
        s.stick    = stick;
        s.tonly    = tonly;
        s.armed    = armed;
        return s;
    endfunction

    // mostly plausible flight samples, some raw noise over the full field ranges
    function automatic ctl_sample_t rand_sample();
        ctl_sample_t s;
        int span;
        if ($urandom_range(99) < 30)
        begin
            s.throttle = CMD_W'($urandom_range(8191));
            s.roll     = TERM_W'($urandom_range(65535));
            s.pitch    = TERM_W'($urandom_range(65535));
            s.yaw      = TERM_W'($urandom_range(65535));
            s.stick    = CMD_W'($urandom_range(8191));
            s.tonly    = 1'($urandom_range(1));
            s.armed    = 1'($urandom_range(1));
        end
        else
        begin
            span       = $urandom_range(1, 1500);
            s.throttle = CMD_W'($urandom_range(0, 5000));
            s.roll     = TERM_W'($urandom_range(0, 2 * span) - span);
            s.pitch    = TERM_W'($urandom_range(0, 2 * span) - span);
            s.yaw      = TERM_W'($urandom_range(0, 2 * span) - span);
            s.stick    = CMD_W'($urandom_range(8191));
            s.tonly    = 1'($urandom_range(1));
            s.armed    = ($urandom_range(99) < 90);
        end
        return s;
    endfunction

    // leaves valid high after the transfer; the next call or drain_outputs moves it
    task automatic send_sample(input ctl_sample_t s);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid              <= 1'b1;
        sample_ch.throttle_level     <= s.throttle;
        sample_ch.roll_term          <= s.roll;
        sample_ch.pitch_term         <= s.pitch;
        sample_ch.yaw_term           <= s.yaw;
        sample_ch.stick_throttle     <= s.stick;
        sample_ch.throttle_only_mode <= s.tonly;
        sample_ch.is_armed           <= s.armed;
        do @(posedge clk); while (!sample_ch.ready);
        predict_motors(s);
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_MIXER_TYPE:    cfg_hex     = val[0];
            CFG_YAW_DIRECTION: cfg_yaw     = val[1:0];
            CFG_MIN_THROTTLE:  cfg_min_thr = val;
            CFG_MAX_THROTTLE:  cfg_max_thr = val;
            CFG_MIN_CHECK:     cfg_min_chk = val;
            CFG_MIN_COMMAND:   cfg_min_cmd = val;
            default:           ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // reset register values, quad layout
    task automatic test_quad_directed();
        send_sample(sample_of(3000, 100, -50, 20, 4000, 1'b0, 1'b1));
        send_sample(sample_of(0, 0, 0, 0, 0, 1'b0, 1'b1));
        send_sample(sample_of(8191, 32767, 32767, 32767, 8191, 1'b1, 1'b1));
        send_sample(sample_of(0, -32768, -32768, -32768, 8191, 1'b1, 1'b1));
        // stick just under and at the low-throttle check
        send_sample(sample_of(3000, 0, 0, 0, 2099, 1'b1, 1'b1));
        send_sample(sample_of(3000, 0, 0, 0, 2100, 1'b1, 1'b1));
        send_sample(sample_of(3000, 0, 0, 0, 0, 1'b0, 1'b1));
        send_sample(sample_of(3500, 700, 0, 0, 8191, 1'b0, 1'b0));
        drain_outputs();
    endtask

    task automatic test_hex_directed();
        write_reg(CFG_MIXER_TYPE, 13'd1);
        // yaw direction of minus two doubles the reversed yaw
        write_reg(CFG_YAW_DIRECTION, 13'h1FFE);
        send_sample(sample_of(3000, 1, 0, 0, 8191, 1'b0, 1'b1));
        send_sample(sample_of(3999, 1, 0, 0, 8191, 1'b0, 1'b1));
        // fractional top motor just over max throttle
        send_sample(sample_of(4000, 3, 0, 0, 8191, 1'b0, 1'b1));
        send_sample(sample_of(8191, 32767, -32768, 32767, 8191, 1'b0, 1'b1));
        send_sample(sample_of(0, -32768, 32767, -32768, 0, 1'b1, 1'b1));
        send_sample(sample_of(2500, 100, 200, 300, 8191, 1'b1, 1'b0));
        drain_outputs();
        write_reg(CFG_YAW_DIRECTION, 13'd0);
        send_sample(sample_of(3000, 10, 20, 1000, 8191, 1'b0, 1'b1));
        drain_outputs();
        write_reg(CFG_YAW_DIRECTION, 13'h1FFF);
        send_sample(sample_of(3000, 10, 20, 1000, 8191, 1'b0, 1'b1));
        drain_outputs();
    endtask

    task automatic test_limit_corners();
        // inverted limits
        write_reg(CFG_MIN_THROTTLE, 13'd5000);
        write_reg(CFG_MAX_THROTTLE, 13'd1000);
        write_reg(CFG_MIN_CHECK, 13'd8191);
        write_reg(CFG_MIN_COMMAND, 13'd8191);
        send_sample(sample_of(3000, 50, -50, 5, 8191, 1'b0, 1'b1));
        send_sample(sample_of(0, 0, 0, 0, 8190, 1'b1, 1'b1));
        send_sample(sample_of(8191, 0, 0, 0, 8190, 1'b0, 1'b0));
        drain_outputs();
        write_reg(CFG_MIXER_TYPE, 13'd0);
        write_reg(CFG_MIN_THROTTLE, 13'd0);
        write_reg(CFG_MAX_THROTTLE, 13'd8191);
        write_reg(CFG_MIN_CHECK, 13'd0);
        write_reg(CFG_MIN_COMMAND, 13'd0);
        send_sample(sample_of(8191, 32767, 32767, -32768, 0, 1'b1, 1'b1));
        send_sample(sample_of(100, -32768, 0, 0, 0, 1'b1, 1'b1));
        send_sample(sample_of(8191, 0, 0, 0, 0, 1'b1, 1'b0));
        drain_outputs();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int count);
        logic [CFG_DAT_W-1:0] lo;
        write_reg(CFG_MIXER_TYPE, CFG_DAT_W'($urandom_range(1)));
        write_reg(CFG_YAW_DIRECTION, CFG_DAT_W'($urandom_range(3)));
        lo = CFG_DAT_W'($urandom_range(0, 3000));
        write_reg(CFG_MIN_THROTTLE, lo);
        if ($urandom_range(99) < 80)
            write_reg(CFG_MAX_THROTTLE, CFG_DAT_W'($urandom_range(lo, 8191)));
        else
            write_reg(CFG_MAX_THROTTLE, CFG_DAT_W'($urandom_range(8191)));
        write_reg(CFG_MIN_CHECK, CFG_DAT_W'($urandom_range(0, 3000)));
        write_reg(CFG_MIN_COMMAND, CFG_DAT_W'($urandom_range(8191)));
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) send_sample(rand_sample());
        drain_outputs();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // output held off long enough that the mixer backs up into its input
    task automatic test_output_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_stamp++;
        repeat (16) send_sample(rand_sample());
        drain_outputs();
    endtask

    always @(negedge clk)
    begin : motor_sink
        if (hold_stamp != hold_seen)
        begin
            hold_seen = hold_stamp;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            motor_ch.ready <= 1'b0;
        end
        else
        begin
            motor_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : motor_check
        motor_cmd_t want;
        if (rst_n && motor_ch.valid && motor_ch.ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected motor command: idx %0d value %0d last %0b",
                             motor_ch.motor_index, motor_ch.motor_value,
                             motor_ch.last_of_run);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (motor_ch.motor_index !== want.idx || motor_ch.motor_value !== want.value ||
                    motor_ch.last_of_run !== want.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("motor mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                 want.idx, want.value, want.last, motor_ch.motor_index,
                                 motor_ch.motor_value, motor_ch.last_of_run);
                end
            end
        end
    end

    initial
    begin
        rst_n                        = 1'b0;
        sample_ch.valid              = 1'b0;
        sample_ch.throttle_level     = '0;
        sample_ch.roll_term          = '0;
        sample_ch.pitch_term         = '0;
        sample_ch.yaw_term           = '0;
        sample_ch.stick_throttle     = '0;
        sample_ch.throttle_only_mode = 1'b0;
        sample_ch.is_armed           = 1'b0;
        cfg_ch.valid                 = 1'b0;
        cfg_ch.index                 = CFG_MIXER_TYPE;
        cfg_ch.data                  = '0;
        motor_ch.ready               = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_quad_directed();
        test_hex_directed();
        test_limit_corners();
        test_random_traffic(0, 0, 33);
        test_random_traffic(76, 0, 33);
        test_random_traffic(0, 76, 33);
        test_random_traffic(36, 36, 33);
        test_output_backpressure();

        if (error_count == 0 && pending_cmds.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
